>>> src/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants for the triangle min path sum block
// Field widths, default bounds and the element class passed front to back.
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int VALUE_W      = 16;
  localparam int MIN_SUM_W    = 24;
  localparam int NUM_ROWS_W   = 9;
  localparam int MAX_ROWS_DEF = 256;
  localparam int QUEUE_DEPTH  = 2;

  // Position class of one element inside the triangle
  typedef enum logic [1:0] {
    KIND_FIRST_ROW,
    KIND_LEFT_EDGE,
    KIND_RIGHT_EDGE,
    KIND_INNER
  } tmps_kind_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    tmps_kind_t         kind;
    logic               last_row;
  } tmps_item_t;

  localparam int ITEM_W = $bits(tmps_item_t);

endpackage

>>> src/tmps_ram.sv
// ----------------------------------------------------------------------------
// tmps_ram: generic simple dual-port RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module tmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/tmps_front.sv
// ----------------------------------------------------------------------------
// tmps_front: element intake and classification
// Tracks row/column of the next element, tags each with its position class,
// last-row flag and storage slot, and pushes it into the queue.
// ----------------------------------------------------------------------------
module tmps_front #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF,
  parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tmps_pkg::NUM_ROWS_W-1:0] num_rows,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tmps_pkg::VALUE_W-1:0]    in_value,
  output logic                            push_valid,
  input  logic                            push_ready,
  output tmps_pkg::tmps_item_t            push_item,
  output logic [IDX_W-1:0]                push_slot
);
  import tmps_pkg::*;

  localparam int MR_W  = $clog2(MAX_ROWS + 1);
  localparam int CMP_W = (MR_W > NUM_ROWS_W) ? MR_W : NUM_ROWS_W;

  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [CMP_W-1:0] nr_ext, eff_rows;
  logic             last_row, row_end, accept;
  tmps_kind_t       kind;

  assign nr_ext = CMP_W'(num_rows);

  always_comb begin
    if (nr_ext == '0) begin
      eff_rows = CMP_W'(1);
    end else if (nr_ext > CMP_W'(MAX_ROWS)) begin
      eff_rows = CMP_W'(MAX_ROWS);
    end else begin
      eff_rows = nr_ext;
    end
  end

  assign last_row = (CMP_W'(row_r) + CMP_W'(1)) >= eff_rows;
  assign row_end  = col_r >= row_r;

  always_comb begin
    if (row_r == '0) begin
      kind = KIND_FIRST_ROW;
    end else if (col_r == '0) begin
      kind = KIND_LEFT_EDGE;
    end else if (row_end) begin
      kind = KIND_RIGHT_EDGE;
    end else begin
      kind = KIND_INNER;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  assign push_item.value    = in_value;
  assign push_item.kind     = kind;
  assign push_item.last_row = last_row;
  assign push_slot          = col_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

>>> src/tmps_queue.sv
// ----------------------------------------------------------------------------
// tmps_queue: short FIFO between the intake and the update datapath
// Push and pop in the same cycle are allowed, so a full-rate stream passes.
// ----------------------------------------------------------------------------
module tmps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tmps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/tmps_back.sv
// ----------------------------------------------------------------------------
// tmps_back: partial-sum update datapath
// Pops an element, reads the stored sum of its column, then adds the element
// to the smaller neighbor (or the only one; none in row 0), writes back,
// tracks the last-row minimum and posts the result into the output register.
// ----------------------------------------------------------------------------
module tmps_back #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF,
  parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int SUM_W    = tmps_pkg::VALUE_W + 1 + $clog2(MAX_ROWS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  tmps_pkg::tmps_item_t                pop_item,
  input  logic [IDX_W-1:0]                    pop_slot,
  output logic                                ram_we,
  output logic [IDX_W-1:0]                    ram_waddr,
  output logic [SUM_W-1:0]                    ram_wdata,
  output logic [IDX_W-1:0]                    ram_raddr,
  input  logic [SUM_W-1:0]                    ram_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tmps_pkg::MIN_SUM_W-1:0] out_min_sum
);
  import tmps_pkg::*;

  logic                    b_valid_r, b_valid_nxt;
  tmps_item_t              b_item_r;
  logic [IDX_W-1:0]        b_slot_r;
  logic                    fwd_r, fwd_nxt;
  logic signed [SUM_W-1:0] fwd_val_r;
  logic signed [SUM_W-1:0] held_r, run_min_r;
  logic                    out_valid_r;
  logic signed [MIN_SUM_W-1:0] out_min_sum_r;

  logic                    row_end, col0, b_emit, b_go, pop;
  logic signed [SUM_W-1:0] old_here, v_ext, sum, run_min_new;
  logic signed [SUM_W+MIN_SUM_W-1:0] run_min_wide;

  assign row_end = b_item_r.kind inside {KIND_FIRST_ROW, KIND_RIGHT_EDGE};
  assign col0    = b_item_r.kind inside {KIND_FIRST_ROW, KIND_LEFT_EDGE};
  assign b_emit  = b_valid_r && b_item_r.last_row && row_end;
  assign b_go    = b_valid_r && (!b_emit || !out_valid_r || out_ready);
  assign pop     = pop_valid && (!b_valid_r || b_go);
  assign pop_ready = !b_valid_r || b_go;

  // while stalled, keep re-reading the held element's column
  assign ram_raddr = pop ? pop_slot : b_slot_r;

  // the previous element's write to the same column is not yet visible to this read
  assign old_here = fwd_r ? fwd_val_r : $signed(ram_rdata);
  assign v_ext    = {{(SUM_W - VALUE_W){b_item_r.value[VALUE_W-1]}}, b_item_r.value};

  always_comb begin
    case (b_item_r.kind)
      KIND_FIRST_ROW:  sum = v_ext;
      KIND_LEFT_EDGE:  sum = v_ext + old_here;
      KIND_RIGHT_EDGE: sum = v_ext + held_r;
      KIND_INNER:      sum = v_ext + ((held_r < old_here) ? held_r : old_here);
      default:         sum = v_ext;
    endcase
  end

  assign run_min_new  = (col0 || (sum < run_min_r)) ? sum : run_min_r;
  assign run_min_wide = {{MIN_SUM_W{run_min_new[SUM_W-1]}}, run_min_new};

  assign ram_we    = b_go;
  assign ram_waddr = b_slot_r;
  assign ram_wdata = sum;

  assign fwd_nxt     = pop && b_go && (pop_slot == b_slot_r);
  assign b_valid_nxt = pop ? 1'b1 : (b_go ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= pop_item;
      b_slot_r <= pop_slot;
    end
    fwd_val_r <= sum;
    if (b_go && b_emit) begin
      out_min_sum_r <= run_min_wide[MIN_SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      held_r      <= '0;
      run_min_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      fwd_r     <= fwd_nxt;
      if (b_go) begin
        held_r <= b_emit ? '0 : old_here;
        if (b_item_r.last_row) begin
          run_min_r <= run_min_new;
        end
      end
      if (b_go && b_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_min_sum = out_min_sum_r;

endmodule

>>> src/triangle_min_path_sum.sv
// ----------------------------------------------------------------------------
// triangle_min_path_sum: minimum top-to-bottom path sum of a number triangle
// Elements stream in row-major order; one result per triangle.
//
//   channel  direction  payload           transaction
//   in_      input      in_value   16b s  one triangle element
//   out_     output     out_min_sum 24b s minimum path sum, after last element
//   cfg_     input      cfg_num_rows 9b u row count, also applied mid-triangle
//
// One element per cycle while no result stalls; the column RAM is read as an
// element leaves the queue and written as it leaves the update stage, with a
// forward path. out_valid rises as the last element leaves the update stage.
// Synchronous active-low reset; the row-sum RAM needs no clearing.
// A stalled result holds the update stage; the 2-entry queue then fills
// and in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module triangle_min_path_sum #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmps_pkg::NUM_ROWS_W-1:0]       cfg_num_rows,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tmps_pkg::VALUE_W-1:0]   in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tmps_pkg::MIN_SUM_W-1:0] out_min_sum
);
  import tmps_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_W = VALUE_W + 1 + $clog2(MAX_ROWS);
  localparam int Q_W   = ITEM_W + IDX_W;

  logic [NUM_ROWS_W-1:0] num_rows_r;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  tmps_item_t       push_item, pop_item;
  logic [IDX_W-1:0] push_slot, pop_slot;
  logic [Q_W-1:0]   q_push_data, q_pop_data;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_W'(1);
    end else if (cfg_valid) begin
      num_rows_r <= cfg_num_rows;
    end
  end

  tmps_front #(
    .MAX_ROWS (MAX_ROWS),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .num_rows   (num_rows_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_slot  (push_slot)
  );

  assign q_push_data = {push_slot, push_item};
  assign pop_item    = q_pop_data[ITEM_W-1:0];
  assign pop_slot    = q_pop_data[Q_W-1:ITEM_W];

  tmps_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (q_push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (q_pop_data)
  );

  tmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS),
    .AW    (IDX_W)
  ) u_row_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmps_back #(
    .MAX_ROWS (MAX_ROWS),
    .IDX_W    (IDX_W),
    .SUM_W    (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .pop_slot    (pop_slot),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_min_sum (out_min_sum)
  );

endmodule

>>> verif/triangle_min_path_sum_tb.sv
// ----------------------------------------------------------------------------
// triangle_min_path_sum_tb: self-checking bench for triangle_min_path_sum
// Streams number triangles through the element channel under random
// idling and back pressure. A scoreboard tracks the row of partial sums
// and predicts each triangle's minimum path sum. Results are compared in
// order. Covers row-count changes mid-triangle, zero and oversized counts,
// and triangles at both value extremes.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmps_pkg::*;

  localparam real         CLK_PERIOD      = 12.0;
  localparam int unsigned WATCHDOG_CYCLES = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned RANDOM_ELEMS    = 600;
  localparam int unsigned ROW_DEPTH       = MAX_ROWS_DEF;

  typedef enum {VAL_RANDOM, VAL_SMALL, VAL_EDGE, VAL_MIN, VAL_MAX} val_mode_t;

  // Tracks partial sums row by row and holds the min sums still owed.
  class min_path_scoreboard;
    logic signed [MIN_SUM_W:0]   col_sums [ROW_DEPTH];
    int unsigned                 row_at;
    int unsigned                 col_at;
    logic signed [MIN_SUM_W:0]   left_sum;
    logic signed [MIN_SUM_W:0]   bottom_min;
    logic [NUM_ROWS_W-1:0]       rows_reg;
    logic signed [MIN_SUM_W-1:0] expected_min_sums [$];
    int unsigned                 errors;

    function new();
      foreach (col_sums[i]) col_sums[i] = '0;
      row_at     = 0;
      col_at     = 0;
      left_sum   = '0;
      bottom_min = '0;
      rows_reg   = 9'd1;
      errors     = 0;
    endfunction

    function void write_rows(logic [NUM_ROWS_W-1:0] v);
      rows_reg = v;
    endfunction

    function int unsigned row_limit();
      if (rows_reg == 0) return 1;
      if (rows_reg > ROW_DEPTH) return ROW_DEPTH;
      return rows_reg;
    endfunction

    function bit at_start();
      return (row_at == 0) && (col_at == 0);
    endfunction

    function int unsigned pending();
      return expected_min_sums.size();
    endfunction

    function void add_element(logic signed [VALUE_W-1:0] v);
      logic signed [MIN_SUM_W:0] elem;
      logic signed [MIN_SUM_W:0] here;
      logic signed [MIN_SUM_W:0] total;
      int unsigned               slot;
      bit                        at_bottom;
      elem      = v;
      slot      = (col_at < ROW_DEPTH) ? col_at : ROW_DEPTH - 1;
      here      = col_sums[slot];
      at_bottom = (row_at + 1) >= row_limit();
      if (row_at == 0)
        total = elem;
      else if (col_at == 0)
        total = elem + here;
      else if (col_at >= row_at)
        total = elem + left_sum;
      else
        total = elem + ((left_sum < here) ? left_sum : here);
      // old entry becomes the left neighbor of the next column
      left_sum       = here;
      col_sums[slot] = total;
      if (at_bottom)
        bottom_min = (col_at == 0 || total < bottom_min) ? total : bottom_min;
      if (col_at >= row_at) begin
        if (at_bottom) begin
          expected_min_sums.push_back(bottom_min[MIN_SUM_W-1:0]);
          row_at   = 0;
          col_at   = 0;
          left_sum = '0;
        end else begin
          row_at++;
          col_at = 0;
        end
      end else begin
        col_at++;
      end
    endfunction

    function void check_min_sum(logic signed [MIN_SUM_W-1:0] got);
      logic signed [MIN_SUM_W-1:0] want;
      if (expected_min_sums.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected min_sum %0d, nothing outstanding", $time, got);
        return;
      end
      want = expected_min_sums.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: min_sum mismatch: expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [NUM_ROWS_W-1:0]       cfg_num_rows;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [MIN_SUM_W-1:0] out_min_sum;

  min_path_scoreboard sb;
  bit                 quiet;
  bit                 hold_req;
  int unsigned        gap_pct;
  int unsigned        elems_sent;

  triangle_min_path_sum DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_num_rows (cfg_num_rows),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_min_sum  (out_min_sum)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Transactions on both channels are observed at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.add_element(in_value);
    if (rst_n && out_valid && out_ready)
      sb.check_min_sum(out_min_sum);
  end

  function automatic logic signed [VALUE_W-1:0] pick_value(val_mode_t mode);
    logic signed [VALUE_W-1:0] r;
    case (mode)
      VAL_MIN: r = 16'sh8000;
      VAL_MAX: r = 16'sh7FFF;
      VAL_SMALL: begin
        r = 16'($urandom_range(0, 40));
        r = r - 16'sd20;
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       r = 16'sh8000;
          1:       r = 16'sh7FFF;
          2:       r = 16'sh0000;
          3:       r = 16'shFFFF;
          default: r = 16'sh0001;
        endcase
      end
      default: r = 16'($urandom());
    endcase
    return r;
  endfunction

  function automatic val_mode_t random_mode();
    case ($urandom_range(0, 2))
      0:       return VAL_SMALL;
      1:       return VAL_EDGE;
      default: return VAL_RANDOM;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so back-to-back elements need no extra assignment.
  task automatic send_value(logic signed [VALUE_W-1:0] v);
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    elems_sent++;
    @(negedge clk);
  endtask

  // Sends elements until the current triangle is complete
  task automatic send_triangle(val_mode_t mode);
    do
      send_value(pick_value(mode));
    while (!sb.at_start());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rows(logic [NUM_ROWS_W-1:0] v);
    cfg_valid    <= 1'b1;
    cfg_num_rows <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_rows(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("triangle_min_path_sum regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned              k;
    logic [NUM_ROWS_W-1:0]    rows;
    val_mode_t                mode;
    sb           = new();
    quiet        = 1'b0;
    hold_req     = 1'b0;
    gap_pct      = 20;
    elems_sent   = 0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_num_rows = '0;
    in_valid     = 1'b0;
    in_value     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset row count is one: every element is its own triangle
    send_value(16'sh7FFF);
    send_value(16'sh8000);
    settle();
    write_rows(9'd0);
    send_value(16'shFFFF);
    settle();

    // three rows exercise top, both edges and an inner element
    write_rows(9'd3);
    send_value(16'sh8000);
    send_value(16'sh7FFF);
    send_value(16'sh8000);
    send_value(16'sh0001);
    send_value(16'sh8000);
    send_value(16'sh7FFF);
    settle();

    // count lowered below the current row: that row becomes the last
    write_rows(9'd4);
    repeat (3) send_value(pick_value(VAL_EDGE));
    settle();
    write_rows(9'd2);
    repeat (3) send_value(pick_value(VAL_EDGE));
    settle();

    // count lowered in the middle of a row
    write_rows(9'd5);
    repeat (4) send_value(pick_value(VAL_SMALL));
    settle();
    write_rows(9'd1);
    repeat (2) send_value(pick_value(VAL_SMALL));
    settle();

    // count raised after the first row
    write_rows(9'd2);
    send_value(16'sh1234);
    settle();
    write_rows(9'd3);
    send_triangle(VAL_RANDOM);
    settle();

    // long receiver hold while one-element triangles keep coming
    gap_pct  = 0;
    write_rows(9'd1);
    hold_req = 1'b1;
    repeat (40) send_triangle(VAL_RANDOM);
    settle();

    k = elems_sent;
    while (elems_sent < k + RANDOM_ELEMS) begin
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 30;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(0, 9))
        0:             rows = 9'd0;
        1, 2, 3, 4, 5: rows = 9'($urandom_range(1, 4));
        6, 7, 8:       rows = 9'($urandom_range(5, 12));
        default:       rows = 9'($urandom_range(13, 24));
      endcase
      write_rows(rows);
      if ($urandom_range(0, 5) == 0) begin
        mode = random_mode();
        repeat ($urandom_range(1, 20)) send_value(pick_value(mode));
        settle();
        write_rows(9'($urandom_range(0, 12)));
        send_triangle(mode);
      end
      repeat ($urandom_range(1, 6)) send_triangle(random_mode());
      settle();
    end

    // no idling; 511 saturates to the row bound, so four rows pass
    // without an end and the count is then lowered to close row four
    quiet = 1'b1;
    write_rows(9'h1FF);
    repeat (10) send_value(pick_value(VAL_SMALL));
    settle();
    write_rows(9'd5);
    send_triangle(VAL_SMALL);
    settle();

    // value extremes on a deeper triangle
    write_rows(9'd12);
    send_triangle(VAL_MIN);
    settle();
    send_triangle(VAL_MAX);
    settle();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("triangle_min_path_sum regression: pass");
    else
      $display("triangle_min_path_sum regression: fail");
    $finish;
  end

endmodule
